### rtl/bitset_engine_core_macros.svh
// ----------------------------------------------------------------------------
// bitset_engine_core_macros.svh
// Assertion macros for the bit set engine; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BITSET_ENGINE_CORE_MACROS_SVH
`define BITSET_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising edge outside reset.
`define BSE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger, outside reset.
`define BSE_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`else

`define BSE_ASSERT(label, clk, rst_n, prop, msg)

`define BSE_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg)

`endif

`endif

### rtl/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Item types, operation codes and controller interface structs.
// ----------------------------------------------------------------------------
package bse_pkg;

    // Operation codes carried in the kind field
    localparam logic [3:0] KIND_CLEAR_ALL = 4'd0;
    localparam logic [3:0] KIND_SET_ALL   = 4'd1;
    localparam logic [3:0] KIND_TEST_ANY  = 4'd2;
    localparam logic [3:0] KIND_COUNT     = 4'd3;
    localparam logic [3:0] KIND_AND       = 4'd4;
    localparam logic [3:0] KIND_OR        = 4'd5;
    localparam logic [3:0] KIND_XOR       = 4'd6;
    localparam logic [3:0] KIND_ANDNOT    = 4'd7;
    localparam logic [3:0] KIND_WRITE     = 4'd8;
    localparam logic [3:0] KIND_READ      = 4'd9;
    localparam logic [3:0] KIND_FIRST     = 4'd10;
    localparam logic [3:0] KIND_LAST      = 4'd11;
    localparam logic [3:0] KIND_NEXT      = 4'd12;
    localparam logic [3:0] KIND_INSERT    = 4'd13;
    localparam logic [3:0] KIND_ERASE     = 4'd14;

    typedef struct packed {
        logic [3:0]  kind;
        logic [8:0]  position;
        logic        insert_value;
        logic [2:0]  word_index;
        logic [31:0] word_data;
    } in_item_t;

    typedef struct packed {
        logic [8:0]  position_or_count;
        logic        any_set;
        logic [31:0] word_out;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;   // latch the accepted item, set up the walk
        logic rd_issue;    // read the word at the walk pointer
        logic wb_valid;    // read data present: process and write back
        logic res_load;    // move accumulated result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rd_last;     // the read issued now is the last one of the item
    } stat_t;

endpackage

### rtl/bse_ctrl.sv
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer for the bit set engine: accept, word walk, drain, result.
// ----------------------------------------------------------------------------
`include "bitset_engine_core_macros.svh"

module bse_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output bse_pkg::cmd_t  cmd,
    input  bse_pkg::stat_t stat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       wb_pend_reg;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.load_item = s_valid && (state_reg == ST_IDLE);
        cmd.rd_issue  = (state_reg == ST_READ);
        cmd.wb_valid  = wb_pend_reg;
        cmd.res_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_READ;
            end
            ST_READ: begin
                if (stat.rd_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.res_load) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else              m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wb_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wb_pend_reg <= cmd.rd_issue;
            m_valid_reg <= m_valid_next;
        end
    end

    `BSE_ASSERT(a_drain_has_data, aclk, aresetn, (state_reg == ST_DRAIN) |-> wb_pend_reg, "drain without pending word")
    `BSE_ASSERT(a_finish_no_data, aclk, aresetn, (state_reg == ST_FINISH) |-> !wb_pend_reg, "word still pending at finish")
    `BSE_ASSERT_NEXT(a_last_read_drains, aclk, aresetn, (state_reg == ST_READ) && stat.rd_last, (state_reg == ST_DRAIN) && wb_pend_reg, "last read not followed by drain")
    `BSE_ASSERT(a_result_from_finish, aclk, aresetn, $rose(m_valid_reg) |-> ($past(state_reg) == ST_FINISH), "result raised outside finish")

endmodule

### rtl/bse_datapath.sv
// ----------------------------------------------------------------------------
// bse_datapath
// Word store, walk pointer, per-word operation logic and result accumulators.
// ----------------------------------------------------------------------------
module bse_datapath #(
    parameter int SET_WORDS = 8,
    parameter int SET_BITS  = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bse_pkg::in_item_t   s_item,
    output bse_pkg::out_item_t  m_item,
    input  bse_pkg::cmd_t       cmd,
    output bse_pkg::stat_t      stat
);

    localparam int LIVE_BITS  = (SET_BITS < SET_WORDS * 32) ? SET_BITS : SET_WORDS * 32;
    localparam int LIVE_WORDS = (LIVE_BITS + 31) / 32;
    localparam int IW         = (SET_WORDS > 1) ? $clog2(SET_WORDS) : 1;
    localparam int MAXV       = (SET_WORDS * 32 > SET_BITS) ? SET_WORDS * 32 : SET_BITS;
    localparam int LW         = ($clog2(MAXV + 1) > 10) ? $clog2(MAXV + 1) : 10;

    localparam logic [LW-1:0] LIVE_L   = LW'(LIVE_BITS);
    localparam logic [LW-1:0] END_L    = LW'(SET_BITS);
    localparam logic [IW-1:0] LAST_PTR = IW'(LIVE_WORDS - 1);

    // Bits of the word starting at base whose positions lie below lim
    function automatic logic [31:0] below_mask(input logic [LW-1:0] base,
                                               input logic [LW-1:0] lim);
        logic [LW-1:0] diff;
        logic [31:0]   m;
        diff = lim - base;
        if (lim <= base)            m = '0;
        else if (diff >= LW'(32))   m = '1;
        else                        m = ~(32'hFFFF_FFFF << diff[4:0]);
        return m;
    endfunction

    function automatic logic [4:0] low_index(input logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) r = 5'(i);
        end
        return r;
    endfunction

    function automatic logic [4:0] high_index(input logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) r = 5'(i);
        end
        return r;
    endfunction

    function automatic logic [5:0] pop_count(input logic [31:0] v);
        logic [1:0] s1 [16];
        logic [2:0] s2 [8];
        logic [3:0] s3 [4];
        logic [4:0] s4 [2];
        for (int i = 0; i < 16; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        for (int i = 0; i < 8; i++)  s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        for (int i = 0; i < 4; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        for (int i = 0; i < 2; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        return {1'b0, s4[0]} + {1'b0, s4[1]};
    endfunction

    // Word store with per-word valid bits; an unwritten word reads as zero
    logic [31:0]          mem [SET_WORDS];
    logic [SET_WORDS-1:0] vld_reg;

    // Latched item
    logic [3:0]    kind_reg;
    logic [LW-1:0] pos_reg;
    logic          ival_reg;
    logic [31:0]   data_reg;
    logic          wok_reg;

    // Walk and read pipeline
    logic [IW-1:0] ptr_reg;
    logic [IW-1:0] wb_addr_reg;
    logic [31:0]   rd_data_reg;
    logic          rd_vld_reg;

    // Accumulators
    logic [LW-1:0] pc_reg, pc_next;
    logic          any_reg, any_next;
    logic          found_reg, found_next;
    logic          carry_reg, carry_next;
    logic [31:0]   wout_reg, wout_next;

    bse_pkg::out_item_t m_item_reg;

    logic          is_word_op, is_single;
    logic          word_ok;
    logic [IW-1:0] ptr_init;
    logic [LW-1:0] pc_init;

    logic [31:0]   old_word, new_word;
    logic          we;
    logic [LW-1:0] base, pos1;
    logic [31:0]   live_m, b_pos, b_pos1, lim_m, gt_m, eq_m, ge_m;
    logic [31:0]   hits_live, hits_gt, sh_up, sh_dn;

    assign m_item = m_item_reg;

    // Item decode at accept
    assign word_ok = (int'(s_item.word_index) < SET_WORDS);

    always_comb begin
        case (s_item.kind)
            bse_pkg::KIND_ERASE: ptr_init = LAST_PTR;
            bse_pkg::KIND_AND, bse_pkg::KIND_OR, bse_pkg::KIND_XOR, bse_pkg::KIND_ANDNOT,
            bse_pkg::KIND_WRITE, bse_pkg::KIND_READ: ptr_init = IW'(s_item.word_index);
            default: ptr_init = '0;
        endcase
        if (s_item.kind == bse_pkg::KIND_FIRST || s_item.kind == bse_pkg::KIND_NEXT)
            pc_init = END_L;
        else
            pc_init = '0;
    end

    // Word operations and the unused code touch one word only
    assign is_word_op = (kind_reg >= bse_pkg::KIND_AND) && (kind_reg <= bse_pkg::KIND_READ);
    assign is_single  = is_word_op || (kind_reg > bse_pkg::KIND_ERASE);

    always_comb begin
        if (is_single)
            stat.rd_last = 1'b1;
        else if (kind_reg == bse_pkg::KIND_ERASE)
            stat.rd_last = (ptr_reg == '0);
        else
            stat.rd_last = (ptr_reg == LAST_PTR);
    end

    // Per-word masks for the word now at write-back
    always_comb begin
        old_word  = rd_vld_reg ? rd_data_reg : 32'h0;
        base      = LW'({wb_addr_reg, 5'b0});
        pos1      = pos_reg + LW'(1);
        live_m    = below_mask(base, LIVE_L);
        b_pos     = below_mask(base, pos_reg);
        b_pos1    = below_mask(base, pos1);
        lim_m     = b_pos & live_m;
        gt_m      = live_m & ~b_pos1;
        eq_m      = live_m & b_pos1 & ~b_pos;
        ge_m      = live_m & ~b_pos;
        hits_live = old_word & live_m;
        hits_gt   = old_word & gt_m;
        sh_up     = {old_word[30:0], carry_reg};
        sh_dn     = {carry_reg, old_word[31:1]};
    end

    always_comb begin
        new_word   = old_word;
        we         = 1'b0;
        pc_next    = pc_reg;
        any_next   = any_reg;
        found_next = found_reg;
        carry_next = carry_reg;
        wout_next  = wout_reg;
        case (kind_reg)
            bse_pkg::KIND_CLEAR_ALL: begin
                new_word = old_word & ~lim_m;
                we       = 1'b1;
            end
            bse_pkg::KIND_SET_ALL: begin
                new_word = old_word | lim_m;
                we       = 1'b1;
            end
            bse_pkg::KIND_TEST_ANY: begin
                any_next = any_reg | (|(old_word & lim_m));
            end
            bse_pkg::KIND_COUNT: begin
                pc_next = pc_reg + LW'(pop_count(old_word & lim_m));
            end
            bse_pkg::KIND_AND: begin
                new_word = old_word & data_reg;
                we       = wok_reg;
            end
            bse_pkg::KIND_OR: begin
                new_word = old_word | data_reg;
                we       = wok_reg;
            end
            bse_pkg::KIND_XOR: begin
                new_word = old_word ^ data_reg;
                we       = wok_reg;
            end
            bse_pkg::KIND_ANDNOT: begin
                new_word = old_word & ~data_reg;
                we       = wok_reg;
            end
            bse_pkg::KIND_WRITE: begin
                new_word = data_reg;
                we       = wok_reg;
            end
            bse_pkg::KIND_READ: begin
                wout_next = wok_reg ? old_word : 32'h0;
            end
            bse_pkg::KIND_FIRST: begin
                if (!found_reg && (hits_live != '0)) begin
                    pc_next    = base + LW'(low_index(hits_live));
                    found_next = 1'b1;
                end
            end
            bse_pkg::KIND_LAST: begin
                if (hits_live != '0)
                    pc_next = base + LW'(high_index(hits_live)) + LW'(1);
            end
            bse_pkg::KIND_NEXT: begin
                if (!found_reg && (hits_gt != '0)) begin
                    pc_next    = base + LW'(low_index(hits_gt));
                    found_next = 1'b1;
                end
            end
            bse_pkg::KIND_INSERT: begin
                // bits above the position take their lower neighbor, the position takes the value
                new_word   = (old_word & ~(gt_m | eq_m)) | (sh_up & gt_m)
                           | (ival_reg ? eq_m : 32'h0);
                we         = 1'b1;
                carry_next = old_word[31];
            end
            bse_pkg::KIND_ERASE: begin
                // bits from the position up take their upper neighbor; a dead source reads zero
                new_word   = (old_word & ~ge_m) | (sh_dn & {1'b1, live_m[31:1]} & ge_m);
                we         = 1'b1;
                carry_next = old_word[0];
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // Store: one read and one write per cycle
    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[ptr_reg];
        end
        if (cmd.wb_valid && we) begin
            mem[wb_addr_reg] <= new_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (cmd.rd_issue) rd_vld_reg <= vld_reg[ptr_reg];
            if (cmd.wb_valid && we) vld_reg[wb_addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg  <= s_item.kind;
            pos_reg   <= LW'(s_item.position);
            ival_reg  <= s_item.insert_value;
            data_reg  <= s_item.word_data;
            wok_reg   <= word_ok;
            ptr_reg   <= ptr_init;
            pc_reg    <= pc_init;
            any_reg   <= 1'b0;
            found_reg <= 1'b0;
            carry_reg <= 1'b0;
            wout_reg  <= 32'h0;
        end else begin
            if (cmd.rd_issue) begin
                wb_addr_reg <= ptr_reg;
                if (kind_reg == bse_pkg::KIND_ERASE) ptr_reg <= ptr_reg - IW'(1);
                else                                 ptr_reg <= ptr_reg + IW'(1);
            end
            if (cmd.wb_valid) begin
                pc_reg    <= pc_next;
                any_reg   <= any_next;
                found_reg <= found_next;
                carry_reg <= carry_next;
                wout_reg  <= wout_next;
            end
        end
        if (cmd.res_load) begin
            m_item_reg.position_or_count <= 9'(pc_reg);
            m_item_reg.any_set           <= any_reg;
            m_item_reg.word_out          <= wout_reg;
        end
    end

endmodule

### rtl/bitset_engine_core.sv
// ----------------------------------------------------------------------------
// bitset_engine_core
// Bit set of 32-bit words with range, word, search and shift operations.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                       Item                Accepted when
//  input     s_valid s_ready s_item      operation + operands s_valid && s_ready
//  result    m_valid m_ready m_item      position/count, any, word  m_valid && m_ready
//
//  Range, search and shift operations walk the live words through the store's
//  single read port, one word a cycle; an item passes through accept, the reads,
//  the last write-back and the result load.
//  Word operations (and, or, xor, andnot, write, read) touch a single word.
//  Reset clears the per-word valid bits at once; no clearing pass is needed.
//  A stalled result register holds its item; the next item is taken as soon
//  as the result is loaded, whether or not it has been picked up.
//
module bitset_engine_core #(
    parameter int SET_WORDS = 8,
    parameter int SET_BITS  = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bse_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output bse_pkg::out_item_t m_item
);

    // command and status between sequencer and datapath
    bse_pkg::cmd_t  cmd;
    bse_pkg::stat_t stat;

    // Sequencer: accept, advance the walk, drain the last word, hold the result
    bse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Datapath: word store, per-word logic, accumulators and result register
    bse_datapath #(
        .SET_WORDS (SET_WORDS),
        .SET_BITS  (SET_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_item  (m_item),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule
